FILE: rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Operation codes, result status codes, and the command and status bundles
// that pass between the list controller and the list datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // Stream payload widths, padded up to whole bytes
  localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_BITS    = DATA_W + CNT_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_REVERSE = 3'd2,
    OP_INSERT  = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_DUMP    = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Cell row operations
  //   CELL_INS : open a gap at the insert position and write the operand
  //   CELL_MOVE: cells below the target take their successor, the target
  //              takes the front entry (rotate, pop, reverse step)
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_MOVE = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    HELD_KEEP = 2'd0,
    HELD_INC  = 2'd1,
    HELD_DEC  = 2'd2,
    HELD_CLR  = 2'd3
  } held_op_e;

  // Controller to datapath
  typedef struct packed {
    logic             latch_value;
    cell_op_e         cell_op;
    logic             ins_from_scan;
    logic [IDX_W-1:0] move_idx;
    held_op_e         held_op;
    logic             scan_clr;
    logic             scan_en;
    logic             scan_first;
    logic [IDX_W-1:0] scan_idx;
    logic             out_load;
    logic             out_dump;
    logic             out_last;
    status_e          out_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] held;
    logic             out_free;
  } stat_t;

endpackage

FILE: rtl/ole_datapath.sv
// ----------------------------------------------------------------------------
// ole_datapath: entry row, insert scan and result register
// Holds the entries as a row of cells that shift or rotate by command, the
// entry count, the order and position trackers of the insert scan, and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module ole_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [ole_pkg::DATA_W-1:0]   value_i,
  input  ole_pkg::cmd_t                       cmd_i,
  output ole_pkg::stat_t                      stat_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ole_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import ole_pkg::*;

  logic signed [DATA_W-1:0] entries_q [DEPTH];
  logic signed [DATA_W-1:0] entries_d [DEPTH];
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         held_q, held_d;

  logic signed [DATA_W-1:0] prev_q;
  logic                     fall_q, gt_found_q, lt_found_q;
  logic [IDX_W-1:0]         gt_pos_q, lt_pos_q;
  logic signed [DATA_W-1:0] cur;
  logic [IDX_W-1:0]         ins_pos;
  logic [IDX_W-1:0]         tail_pos;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_elem_q;
  logic [CNT_W-1:0]         out_cnt_q;
  status_e                  out_status_q;
  logic                     out_has_q, out_last_q;
  logic                     out_free;

  assign cur      = entries_q[0];
  assign tail_pos = held_q[IDX_W-1:0];

  // Pick the insert position from the scan result
  always_comb begin
    ins_pos = '0;
    if (cmd_i.ins_from_scan) begin
      if (fall_q) begin
        ins_pos = lt_found_q ? lt_pos_q : tail_pos;
      end else begin
        ins_pos = gt_found_q ? gt_pos_q : tail_pos;
      end
    end
  end

  // Next value of each cell: its neighbors, the front entry or the operand only
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      case (cmd_i.cell_op)
        CELL_INS: begin
          if (IDX_W'(i) == ins_pos) begin
            entries_d[i] = value_q;
          end else if (IDX_W'(i) > ins_pos && i > 0) begin
            entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
          end
        end
        CELL_MOVE: begin
          if (IDX_W'(i) == cmd_i.move_idx) begin
            entries_d[i] = entries_q[0];
          end else if (IDX_W'(i) < cmd_i.move_idx && i < DEPTH - 1) begin
            entries_d[i] = entries_q[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
        default: begin
          entries_d[i] = entries_q[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  // Capture the operand of an accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_value) begin
      value_q <= value_i;
    end
  end

  // Entry count
  always_comb begin
    case (cmd_i.held_op)
      HELD_INC: held_d = held_q + CNT_W'(1);
      HELD_DEC: held_d = held_q - CNT_W'(1);
      HELD_CLR: held_d = '0;
      default:  held_d = held_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  // Track order and both candidate positions while the row rotates past
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_q     <= 1'b0;
      gt_found_q <= 1'b0;
      lt_found_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      fall_q     <= 1'b0;
      gt_found_q <= 1'b0;
      lt_found_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      if (!cmd_i.scan_first && prev_q > cur) begin
        fall_q <= 1'b1;
      end
      if (!gt_found_q && cur > value_q) begin
        gt_found_q <= 1'b1;
      end
      if (!lt_found_q && cur < value_q) begin
        lt_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      prev_q <= cur;
      if (!gt_found_q) begin
        gt_pos_q <= cmd_i.scan_idx;
      end
      if (!lt_found_q) begin
        lt_pos_q <= cmd_i.scan_idx;
      end
    end
  end

  // Result register: load when free, drop valid once the transfer is taken
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_elem_q   <= cmd_i.out_dump ? entries_q[0] : '0;
      out_has_q    <= cmd_i.out_dump;
      out_last_q   <= cmd_i.out_last;
      out_cnt_q    <= held_q;
      out_status_q <= cmd_i.out_status;
    end
  end

  assign stat_o.held     = held_q;
  assign stat_o.out_free = out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_status_q, out_cnt_q,
                          out_elem_q};
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over an untaken transfer");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cell_op == CELL_INS) |-> (held_q != CNT_W'(DEPTH)))
    else $error("insert into a full row");

  a_inc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.held_op == HELD_INC) |=> (held_q == $past(held_q) + CNT_W'(1)))
    else $error("entry count did not advance");

endmodule

FILE: rtl/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl: operation sequencer of the ordered list engine
// Accepts one operation at a time, steps the datapath through the scan,
// reverse and dump walks, and issues the result transfers.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ole_pkg::OP_W-1:0]      op_i,
  input  ole_pkg::stat_t                stat_i,
  output ole_pkg::cmd_t                 cmd_o
);
  import ole_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_INSERT = 7'b0001000,
    S_REV    = 7'b0010000,
    S_DUMP   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  status_e          status_q, status_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] k_next;
  logic [CNT_W-1:0] held_m1;
  logic [CNT_W-1:0] rev_idx;
  logic             full, empty;
  logic             accept;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign full    = (stat_i.held == CNT_W'(DEPTH));
  assign empty   = (stat_i.held == '0);
  assign k_next  = {1'b0, k_q} + CNT_W'(1);
  assign held_m1 = stat_i.held - CNT_W'(1);
  assign rev_idx = held_m1 - {1'b0, k_q};

  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    k_d      = k_q;
    cmd_o    = '0;
    cmd_o.cell_op    = CELL_HOLD;
    cmd_o.held_op    = HELD_KEEP;
    cmd_o.out_status = status_q;
    cmd_o.scan_idx   = k_q;
    cmd_o.move_idx   = held_m1[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch_value = 1'b1;
          op_d     = op_i;
          status_d = ST_DONE;
          k_d      = '0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        case (op_q)
          OP_PUSH: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              cmd_o.cell_op = CELL_INS;
              cmd_o.held_op = HELD_INC;
            end
          end
          OP_POP: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              cmd_o.cell_op = CELL_MOVE;
              cmd_o.held_op = HELD_DEC;
            end
          end
          OP_REVERSE: begin
            if (stat_i.held > CNT_W'(1)) begin
              state_d = S_REV;
            end
          end
          OP_INSERT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d = empty ? S_INSERT : S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd_o.held_op = HELD_CLR;
          end
          OP_DUMP: begin
            if (!empty) begin
              state_d = S_DUMP;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Rotate the row once around, watching each entry at the front
      S_SCAN: begin
        cmd_o.cell_op    = CELL_MOVE;
        cmd_o.scan_en    = 1'b1;
        cmd_o.scan_first = (k_q == '0);
        k_d = k_q + IDX_W'(1);
        if (k_next == stat_i.held) begin
          state_d = S_INSERT;
        end
      end

      S_INSERT: begin
        cmd_o.cell_op       = CELL_INS;
        cmd_o.ins_from_scan = 1'b1;
        cmd_o.held_op       = HELD_INC;
        state_d = S_RESP;
      end

      // Move the front entry to the shrinking tail, one step per cycle
      S_REV: begin
        cmd_o.cell_op  = CELL_MOVE;
        cmd_o.move_idx = rev_idx[IDX_W-1:0];
        k_d = k_q + IDX_W'(1);
        if (k_next + CNT_W'(1) == stat_i.held) begin
          state_d = S_RESP;
        end
      end

      // Send the front entry and rotate, one per free output slot
      S_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_dump = 1'b1;
          cmd_o.out_last = (k_next == stat_i.held);
          cmd_o.cell_op  = CELL_MOVE;
          k_d = k_q + IDX_W'(1);
          if (k_next == stat_i.held) begin
            state_d = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= '0;
      status_q <= ST_DONE;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
      k_q      <= k_d;
    end
  end

  // Checks
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !empty)
    else $error("dump walk over an empty row");

  a_scan_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !full)
    else $error("insert scan on a full row");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted item not dispatched");

endmodule

FILE: rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded list of signed 32-bit values
// Takes one list operation per input transfer (push front, pop front,
// reverse, ordered insert, clear, dump) and returns its result transfers.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation code, tdata the operand value.
//   Output stream: one transfer per operation, tlast high; a dump sends one
//   transfer per held entry from front to back, tlast on the final one, and
//   tuser high where tdata carries an entry. An empty dump sends one
//   transfer with tuser low.
//   The block works on one operation at a time; tready is high only while
//   it waits for the next item. What each operation does (n = entries held):
//     push, pop, clear, unused codes, rejects on a full list: a direct result
//     ordered insert: one rotation of the entry row to find order and
//       position, then the insert
//     reverse: n - 1 front-to-tail moves, none below two entries
//     dump: one entry leaves the row per output transfer; a single
//       transfer if empty
//   A stalled receiver holds the result register; the block waits with it
//   and resumes when the transfer completes.
//   Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ole_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] value
  input  logic [ole_pkg::OP_W-1:0]          s_axis_tuser,  // [2:0] op
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ole_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [31:0] element,
                                                           // [36:32] entry_count,
                                                           // [38:37] status
  output logic                              m_axis_tuser,  // [0] has_element
  output logic                              m_axis_tlast
);
  import ole_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ole_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_i          (s_axis_tuser),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  ole_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (s_axis_tdata[DATA_W-1:0]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: bench/tb_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine: self-checking bench for the ordered list engine
// Walks a short directed table (empty-store cases, value extremes, order
// detection, filling the store up to the full rejects), then about 280 random
// operations. Every input transfer is run through a behavioral list model
// kept in the bench; each output transfer is checked field by field against
// the oldest pending expectation. Both streams idle at random, the receiver
// holds off once for a long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int N_RANDOM    = 280;
  localparam int N_DIRECTED  = 26;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 40;

  // Op codes outside the defined set; the block must treat them as no-ops
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] element;
    logic              has_element;
    logic              last;
    logic [CNT_W-1:0]  entry_count;
    status_e           status;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic              fixed;   // expected result typed in below
    logic [CNT_W-1:0]  count;
    status_e           status;
  } list_cmd_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] value
  logic [OP_W-1:0]        s_axis_tuser;   // [2:0] op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] element, [36:32] entry_count,
                                          // [38:37] status
  logic                   m_axis_tuser;   // [0] has_element
  logic                   m_axis_tlast;

  ordered_list_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Directed table: empty-store cases, extremes, order detection, fill to full
  list_cmd_t directed_cmds [N_DIRECTED] = '{
    '{OP_DUMP,    32'h0,       1'b1, 5'd0,  ST_DONE},
    '{OP_POP,     32'h0,       1'b1, 5'd0,  ST_EMPTY},
    '{OP_REVERSE, 32'h0,       1'b1, 5'd0,  ST_DONE},
    '{OP_CLEAR,   32'h0,       1'b1, 5'd0,  ST_DONE},
    '{OP_INSERT,  VAL_MAX,     1'b1, 5'd1,  ST_DONE},
    '{OP_INSERT,  VAL_MIN,     1'b0, 5'd0,  ST_DONE},
    '{OP_REVERSE, 32'h0,       1'b0, 5'd0,  ST_DONE},
    '{OP_INSERT,  32'h0,       1'b0, 5'd0,  ST_DONE},
    '{OP_RSVD6,   32'hFFFFFFFF, 1'b0, 5'd0, ST_DONE},
    '{OP_RSVD7,   32'h55555555, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'hFFFFFFFF, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'h00000001, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    VAL_MIN,     1'b0, 5'd0,  ST_DONE},
    '{OP_PUSH,    VAL_MAX,     1'b0, 5'd0,  ST_DONE},
    '{OP_PUSH,    32'h00000000, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'hAAAAAAAA, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'h55555555, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'hFFFFFFFE, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'h80000001, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'h7FFFFFFE, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'h12345678, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'hEDCBA987, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'h00000002, 1'b0, 5'd0, ST_DONE},
    '{OP_PUSH,    32'hDEADBEEF, 1'b1, 5'd16, ST_FULL},
    '{OP_INSERT,  32'h0,       1'b1, 5'd16, ST_FULL},
    '{OP_DUMP,    32'h0,       1'b0, 5'd0,  ST_DONE}
  };

  // Bench copy of the list
  logic signed [DATA_W-1:0] list_entries [DEPTH];
  int                       list_held;

  list_result_t pending_results [$];
  int           failures;
  int           sent_ops;
  int           cycle_count;
  logic         quiet;

  // No random idling on either side over a window of the random part
  assign quiet = (sent_ops >= N_DIRECTED + 40) && (sent_ops < N_DIRECTED + 100);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Queue one expected result transfer
  task automatic expect_result(input logic [DATA_W-1:0] element, input logic has,
                               input logic last, input status_e status);
    list_result_t r;
    r.element     = element;
    r.has_element = has;
    r.last        = last;
    r.entry_count = CNT_W'(list_held);
    r.status      = status;
    pending_results.push_back(r);
  endtask

  // Open a gap at pos and write the value there
  task automatic list_insert_at(input int pos, input logic [DATA_W-1:0] value);
    for (int i = list_held; i > pos; i--) list_entries[i] = list_entries[i-1];
    list_entries[pos] = value;
    list_held++;
  endtask

  // Apply one operation to the bench list; queue its results when asked
  task automatic predict_list_op(input logic [OP_W-1:0] op,
                                 input logic [DATA_W-1:0] value, input bit record);
    status_e                  status;
    logic signed [DATA_W-1:0] tmp;
    logic signed [DATA_W-1:0] sval;
    bit                       falling;
    int                       pos;
    status  = ST_DONE;
    sval    = value;
    falling = 1'b0;
    pos     = 0;
    case (op)
      OP_PUSH: begin
        if (list_held >= DEPTH) status = ST_FULL;
        else list_insert_at(0, value);
      end
      OP_POP: begin
        if (list_held == 0) status = ST_EMPTY;
        else begin
          for (int i = 0; i + 1 < list_held; i++) list_entries[i] = list_entries[i+1];
          list_held--;
        end
      end
      OP_REVERSE: begin
        for (int i = 0; i < list_held / 2; i++) begin
          tmp = list_entries[i];
          list_entries[i] = list_entries[list_held-1-i];
          list_entries[list_held-1-i] = tmp;
        end
      end
      OP_INSERT: begin
        if (list_held >= DEPTH) status = ST_FULL;
        else begin
          // Any falling pair makes the list descending
          for (int i = 0; i + 1 < list_held; i++)
            if (list_entries[i] > list_entries[i+1]) falling = 1'b1;
          pos = list_held;
          for (int i = list_held - 1; i >= 0; i--)
            if (falling ? (list_entries[i] < sval) : (list_entries[i] > sval)) pos = i;
          list_insert_at(pos, value);
        end
      end
      OP_CLEAR: list_held = 0;
      OP_DUMP: begin
        if (record && list_held != 0) begin
          for (int i = 0; i < list_held; i++)
            expect_result(list_entries[i], 1'b1, i == list_held - 1, ST_DONE);
        end
      end
      default: ;
    endcase
    if (record && !(op == OP_DUMP && list_held != 0))
      expect_result('0, 1'b0, 1'b1, status);
  endtask

  // Offer one operation, called and returning at a falling edge
  task automatic send_list_op(input list_cmd_t cmd);
    list_result_t r;
    while (!quiet && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cmd.value;
    s_axis_tuser  <= cmd.op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_list_op(cmd.op, cmd.value, !cmd.fixed);
    if (cmd.fixed) begin
      r.element     = '0;
      r.has_element = 1'b0;
      r.last        = 1'b1;
      r.entry_count = cmd.count;
      r.status      = cmd.status;
      pending_results.push_back(r);
    end
    sent_ops++;
    @(negedge clk_i);
  endtask

  // Random operation: inserts and pushes most often, values often close together
  function automatic list_cmd_t random_list_op();
    list_cmd_t cmd;
    int        pick;
    cmd  = '0;
    pick = $urandom_range(0, 99);
    if (pick < 28)      cmd.op = OP_INSERT;
    else if (pick < 48) cmd.op = OP_PUSH;
    else if (pick < 63) cmd.op = OP_POP;
    else if (pick < 73) cmd.op = OP_REVERSE;
    else if (pick < 87) cmd.op = OP_DUMP;
    else if (pick < 93) cmd.op = OP_CLEAR;
    else if (pick < 96) cmd.op = OP_RSVD6;
    else                cmd.op = OP_RSVD7;
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd.value = DATA_W'(int'($urandom_range(0, 15)) - 8);
    else if (pick < 50) begin
      case ($urandom_range(0, 3))
        0:       cmd.value = VAL_MIN;
        1:       cmd.value = VAL_MAX;
        2:       cmd.value = '0;
        default: cmd.value = '1;
      endcase
    end else cmd.value = $urandom;
    return cmd;
  endfunction

  // Stimulus
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    failures      = 0;
    sent_ops      = 0;
    list_held     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_cmds[i]) send_list_op(directed_cmds[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      // Drain once so the block sees an input gap with nothing in flight
      if (n == 180) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (pending_results.size() != 0);
      end
      send_list_op(random_list_op());
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Receiver: random back-pressure plus one long hold-off
  initial begin
    int  hold_left;
    bit  hold_armed;
    hold_left  = 0;
    hold_armed = 1'b1;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && sent_ops >= N_DIRECTED + 120) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: element %0d", $signed(m_axis_tdata[DATA_W-1:0]));
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.element) begin
          $error("element: expected %0d, got %0d", $signed(want.element),
                 $signed(m_axis_tdata[DATA_W-1:0]));
          failures++;
        end
        if (m_axis_tuser !== want.has_element) begin
          $error("has_element: expected %0d, got %0d", want.has_element, m_axis_tuser);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          failures++;
        end
        if (m_axis_tdata[DATA_W +: CNT_W] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_axis_tdata[DATA_W +: CNT_W]);
          failures++;
        end
        if (m_axis_tdata[DATA_W+CNT_W +: STAT_W] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 m_axis_tdata[DATA_W+CNT_W +: STAT_W]);
          failures++;
        end
      end
    end
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/ole_pkg.sv
rtl/ole_datapath.sv
rtl/ole_ctrl.sv
rtl/ordered_list_engine.sv
bench/tb_ordered_list_engine.sv
